// ----- design/nrbs_pkg.sv -----
// Shared types, codes and helpers for the NMEA ring buffer scanner.
`default_nettype none
package nrbs_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OUT_W = 10;

   typedef logic [IDX_W-1:0] idx_type;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SEEK  = 2'd1;
   localparam logic [1:0] CMD_FIELD = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NO_MSG   = 2'd2;
   localparam logic [1:0] STAT_NO_DELIM = 2'd3;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEEK,
      S_FIELD
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_REPORT,
      ACT_WRITE,
      ACT_SEEK_INIT,
      ACT_FIELD_INIT,
      ACT_STEP,
      ACT_SEEK_HIT,
      ACT_SEEK_MISS,
      ACT_FIELD_HIT,
      ACT_FIELD_MISS
   } act_type;

   typedef struct packed {
      act_type    act;
      logic [1:0] status;
      logic [7:0] data;
   } scan_ctl_type;

   typedef struct packed {
      logic empty;
      logic one_left;
      logic at_write;
   } scan_flag_type;

   typedef struct packed {
      logic [1:0] status;
      idx_type    start;
      idx_type    length;
      idx_type    fill;
   } scan_rsp_type;

   function automatic logic is_start_mark(input logic [7:0] b);
      return (b == CH_DOLLAR) || (b == CH_BANG);
   endfunction

   function automatic logic is_field_end(input logic [7:0] b);
      return (b == CH_COMMA) || (b == CH_STAR) || (b == CH_CR);
   endfunction

endpackage
`default_nettype wire

// ----- design/nmea_ring_buffer_scanner_unit.sv -----
// Top level: command sequencer, result register and checks for the NMEA ring scanner.
//
// Usage: drive req_cmd and req_data_byte with start high; the word is taken on
// a rising edge where start is high and busy is low. Every command returns one
// result word on the rsp_ ports, marked by rsp_valid for exactly one cycle.
//   cmd 0 (write byte): result in the cycle after acceptance; busy stays low, so
//     one byte per cycle is sustained.
//   cmd 1 (seek '$' or '!') and cmd 2 (next field): the scan pointer walks the
//     ring one byte per cycle through a single registered read port; busy stays
//     high while the scan runs, and the result is registered when it ends.
//   Unused command 3 and a seek on an empty ring answer in the cycle after acceptance.
// Reset clears the write, read and field pointers, not the scan pointer; ring
// contents are not cleared, and a field scan can read bytes not written since reset.
// The receiver cannot stall: each result is taken in its strobe cycle, and the
// result register is free again before the next result can form.
`default_nettype none
module nmea_ring_buffer_scanner_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [9:0]      rsp_field_start,
   output logic [9:0]      rsp_field_length,
   output logic [9:0]      rsp_fill_count
);

   nrbs_pkg::state_type     state_ff, state_in;
   nrbs_pkg::scan_ctl_type  ctl;
   nrbs_pkg::scan_flag_type flags;
   nrbs_pkg::scan_rsp_type  rsp;
   logic                    finish;
   logic                    accept;
   logic                    wr_en;
   nrbs_pkg::idx_type       wr_addr;
   logic [7:0]              wr_data;
   nrbs_pkg::idx_type       rd_addr;
   logic [7:0]              rd_data;

   logic                    rsp_valid_ff;
   logic [1:0]              status_ff;
   logic [9:0]              start_ff;
   logic [9:0]              length_ff;
   logic [9:0]              fill_ff;

   nrbs_ring_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nrbs_scan_unit u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .flags   (flags),
      .rsp     (rsp),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr)
   );

   assign busy   = (state_ff != nrbs_pkg::S_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrbs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      finish     = 1'b0;
      ctl.act    = nrbs_pkg::ACT_NONE;
      ctl.status = nrbs_pkg::STAT_OK;
      ctl.data   = req_data_byte;
      case (state_ff)
         nrbs_pkg::S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  nrbs_pkg::CMD_WRITE: begin
                     ctl.act = nrbs_pkg::ACT_WRITE;
                     finish  = 1'b1;
                  end
                  nrbs_pkg::CMD_SEEK: begin
                     if (flags.empty) begin
                        ctl.act    = nrbs_pkg::ACT_REPORT;
                        ctl.status = nrbs_pkg::STAT_NO_MSG;
                        finish     = 1'b1;
                     end else begin
                        ctl.act  = nrbs_pkg::ACT_SEEK_INIT;
                        state_in = nrbs_pkg::S_SEEK;
                     end
                  end
                  nrbs_pkg::CMD_FIELD: begin
                     ctl.act  = nrbs_pkg::ACT_FIELD_INIT;
                     state_in = nrbs_pkg::S_FIELD;
                  end
                  default: begin
                     ctl.act = nrbs_pkg::ACT_REPORT;
                     finish  = 1'b1;
                  end
               endcase
            end
         end
         nrbs_pkg::S_SEEK: begin
            // rd_data holds the byte under the scan pointer
            if (nrbs_pkg::is_start_mark(rd_data)) begin
               ctl.act  = nrbs_pkg::ACT_SEEK_HIT;
               finish   = 1'b1;
               state_in = nrbs_pkg::S_IDLE;
            end else if (!flags.one_left) begin
               ctl.act = nrbs_pkg::ACT_STEP;
            end else begin
               ctl.act  = nrbs_pkg::ACT_SEEK_MISS;
               finish   = 1'b1;
               state_in = nrbs_pkg::S_IDLE;
            end
         end
         nrbs_pkg::S_FIELD: begin
            if (flags.at_write) begin
               ctl.act  = nrbs_pkg::ACT_FIELD_MISS;
               finish   = 1'b1;
               state_in = nrbs_pkg::S_IDLE;
            end else if (nrbs_pkg::is_field_end(rd_data)) begin
               ctl.act  = nrbs_pkg::ACT_FIELD_HIT;
               finish   = 1'b1;
               state_in = nrbs_pkg::S_IDLE;
            end else begin
               ctl.act = nrbs_pkg::ACT_STEP;
            end
         end
         default: begin
            state_in = nrbs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= rsp.status;
         start_ff  <= nrbs_pkg::OUT_W'(rsp.start);
         length_ff <= nrbs_pkg::OUT_W'(rsp.length);
         fill_ff   <= nrbs_pkg::OUT_W'(rsp.fill);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_field_start  = start_ff;
   assign rsp_field_length = length_ff;
   assign rsp_fill_count   = fill_ff;

   a_write_answers_next: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == nrbs_pkg::CMD_WRITE) |=> rsp_valid)
      else $error("write word not answered in the next cycle");

   a_scan_no_early_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == nrbs_pkg::CMD_FIELD) |=> !rsp_valid && busy)
      else $error("field scan answered before reading the ring");

   a_full_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == nrbs_pkg::STAT_FULL)
      |-> rsp_fill_count == 10'(nrbs_pkg::DEPTH - 1))
      else $error("full status with fill count below capacity");

   a_busy_no_strobe_end: assert property (@(posedge clock) disable iff (reset)
      busy && !$past(busy) |-> !rsp_valid)
      else $error("result strobe while a scan has only just started");

endmodule
`default_nettype wire

// ----- design/nrbs_ring_mem.sv -----
// Byte ring storage: one write port, one registered read port.
`default_nettype none
module nrbs_ring_mem (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire nrbs_pkg::idx_type wr_addr,
   input  wire logic [7:0]       wr_data,
   input  wire nrbs_pkg::idx_type rd_addr,
   output logic [7:0]            rd_data
);

   logic [7:0] ring_ff [nrbs_pkg::DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/nrbs_scan_unit.sv -----
// Ring pointers, field pointers and the shared scan pointer with its incrementer.
`default_nettype none
module nrbs_scan_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nrbs_pkg::scan_ctl_type ctl,
   output nrbs_pkg::scan_flag_type     flags,
   output nrbs_pkg::scan_rsp_type      rsp,
   output logic                        wr_en,
   output nrbs_pkg::idx_type           wr_addr,
   output logic [7:0]                  wr_data,
   output nrbs_pkg::idx_type           rd_addr
);

   nrbs_pkg::idx_type wp_ff, wp_in;
   nrbs_pkg::idx_type rp_ff, rp_in;
   nrbs_pkg::idx_type beg_ff, beg_in;
   nrbs_pkg::idx_type fin_ff, fin_in;
   nrbs_pkg::idx_type pos_ff, pos_in;
   nrbs_pkg::idx_type start_ff, start_in;
   nrbs_pkg::idx_type inc_base;
   nrbs_pkg::idx_type inc;
   nrbs_pkg::idx_type fill;
   nrbs_pkg::idx_type fill_pos;
   logic              full;

   always_comb begin
      fill     = wp_ff - rp_ff;
      fill_pos = wp_ff - pos_ff;
      full     = (fill == nrbs_pkg::idx_type'(nrbs_pkg::DEPTH - 1));
      inc_base = (ctl.act == nrbs_pkg::ACT_FIELD_INIT) ? fin_ff : pos_ff;
      inc      = inc_base + nrbs_pkg::idx_type'(1);

      wp_in    = wp_ff;
      rp_in    = rp_ff;
      beg_in   = beg_ff;
      fin_in   = fin_ff;
      pos_in   = pos_ff;
      start_in = start_ff;

      rsp.status = ctl.status;
      rsp.start  = beg_ff;
      rsp.length = fin_ff - beg_ff;
      rsp.fill   = fill;

      case (ctl.act)
         nrbs_pkg::ACT_WRITE: begin
            wp_in = wp_ff + nrbs_pkg::idx_type'(1);
            if (full) begin
               // drop the oldest byte
               rp_in      = rp_ff + nrbs_pkg::idx_type'(1);
               rsp.status = nrbs_pkg::STAT_FULL;
            end else begin
               rsp.status = nrbs_pkg::STAT_OK;
               rsp.fill   = fill + nrbs_pkg::idx_type'(1);
            end
         end
         nrbs_pkg::ACT_SEEK_INIT: begin
            pos_in = rp_ff;
         end
         nrbs_pkg::ACT_FIELD_INIT: begin
            pos_in   = inc;
            start_in = inc;
         end
         nrbs_pkg::ACT_STEP: begin
            pos_in = inc;
         end
         nrbs_pkg::ACT_SEEK_HIT: begin
            rp_in      = pos_ff;
            beg_in     = pos_ff;
            fin_in     = pos_ff;
            rsp.status = nrbs_pkg::STAT_OK;
            rsp.start  = pos_ff;
            rsp.length = '0;
            rsp.fill   = fill_pos;
         end
         nrbs_pkg::ACT_SEEK_MISS: begin
            rp_in      = pos_ff;
            rsp.status = nrbs_pkg::STAT_NO_MSG;
            rsp.fill   = fill_pos;
         end
         nrbs_pkg::ACT_FIELD_HIT: begin
            beg_in     = start_ff;
            fin_in     = pos_ff;
            rsp.status = nrbs_pkg::STAT_OK;
            rsp.start  = start_ff;
            rsp.length = pos_ff - start_ff;
         end
         nrbs_pkg::ACT_FIELD_MISS: begin
            // keep field pointers so the scan can be retried later
            rsp.status = nrbs_pkg::STAT_NO_DELIM;
            rsp.start  = start_ff;
            rsp.length = pos_ff - start_ff;
         end
         default: begin
         end
      endcase

      flags.empty    = (wp_ff == rp_ff);
      flags.at_write = (pos_ff == wp_ff);
      flags.one_left = (fill_pos <= nrbs_pkg::idx_type'(1));

      wr_en   = (ctl.act == nrbs_pkg::ACT_WRITE);
      wr_addr = wp_ff;
      wr_data = ctl.data;
      rd_addr = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         beg_ff <= '0;
         fin_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         beg_ff <= beg_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      start_ff <= start_in;
   end

endmodule
`default_nettype wire
